>>> hw/rtl/hysteresis_switch_state_top_defines.svh
// Assertion macros used by the top module of the hysteresis switch block.
`ifndef HYSTERESIS_SWITCH_STATE_TOP_DEFINES_SVH
`define HYSTERESIS_SWITCH_STATE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define HSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hysteresis switch check failed");

// The consequent must hold in the cycle after the antecedent.
`define HSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hysteresis switch check failed");

`else

`define HSS_ASSERT_NOW(label, ante, cons)
`define HSS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hw/rtl/hss_pkg.sv
// Types, codes and reset values for the hysteresis switch block.
package hss_pkg;

  // Switch states, ordered from fully off to fully on.
  typedef enum logic [1:0] {
    ST_REALLY_OFF = 2'd0,
    ST_HYST_OFF   = 2'd1,
    ST_HYST_ON    = 2'd2,
    ST_REALLY_ON  = 2'd3
  } sw_state_t;

  // Simulation phase codes carried with each item.
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_INIT  = 3'd1;
  localparam logic [2:0] ACT_SMSIG = 3'd2;
  localparam logic [2:0] ACT_CORR  = 3'd3;
  localparam logic [2:0] ACT_PRED  = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_HYST      = 3'd1;
  localparam logic [2:0] REG_START_ON  = 3'd2;
  localparam logic [2:0] REG_ON_COND   = 3'd3;
  localparam logic [2:0] REG_OFF_COND  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [31:0] ON_COND_RESET  = 32'h0001_0000;
  localparam logic [31:0] OFF_COND_RESET = 32'h0000_0000;

  // Registered configuration, with the hysteresis kept as magnitude and sign.
  typedef struct packed {
    logic signed [31:0] threshold;
    logic [31:0]        hyst_mag;
    logic               hyst_neg;
    logic               hyst_zero;
    logic               start_on;
    logic [31:0]        on_cond;
    logic [31:0]        off_cond;
  } cfg_t;

  // Request to reload both stored switch states.
  typedef struct packed {
    logic      valid;
    sw_state_t value;
  } state_load_t;

endpackage

>>> hw/rtl/hss_cfg.sv
// Configuration registers of the hysteresis switch block.
module hss_cfg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  output hss_pkg::cfg_t        cfg,
  output hss_pkg::state_load_t load
);

  logic        wr_fire;
  logic [31:0] mag_next;

  // Writes are always taken.
  assign cfg_ready = 1'b1;
  assign wr_fire   = cfg_valid && cfg_ready;

  // Magnitude of the written hysteresis; the most negative value maps to 2^31.
  assign mag_next = cfg_data[31] ? (~cfg_data + 32'd1) : cfg_data;

  // Writing start_on reloads both stored states.
  always_comb begin
    load.valid = wr_fire && (cfg_index == hss_pkg::REG_START_ON);
    load.value = cfg_data[0] ? hss_pkg::ST_HYST_ON : hss_pkg::ST_HYST_OFF;
  end

  // Register file; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= '0;
      cfg.hyst_mag  <= '0;
      cfg.hyst_neg  <= 1'b0;
      cfg.hyst_zero <= 1'b1;
      cfg.start_on  <= 1'b0;
      cfg.on_cond   <= hss_pkg::ON_COND_RESET;
      cfg.off_cond  <= hss_pkg::OFF_COND_RESET;
    end else if (wr_fire) begin
      unique case (cfg_index)
        hss_pkg::REG_THRESHOLD: cfg.threshold <= $signed(cfg_data);
        hss_pkg::REG_HYST: begin
          cfg.hyst_mag  <= mag_next;
          cfg.hyst_neg  <= cfg_data[31];
          cfg.hyst_zero <= (cfg_data == 32'd0);
        end
        hss_pkg::REG_START_ON:  cfg.start_on <= cfg_data[0];
        hss_pkg::REG_ON_COND:   cfg.on_cond  <= cfg_data;
        hss_pkg::REG_OFF_COND:  cfg.off_cond <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/hss_next.sv
// Next-state rule of the switch: band compare and per-phase selection.
module hss_next (
  input  logic signed [31:0]  level,
  input  logic [2:0]          action,
  input  hss_pkg::sw_state_t  old_state,
  input  hss_pkg::sw_state_t  prior,
  input  hss_pkg::cfg_t       cfg,
  output hss_pkg::sw_state_t  next_state
);

  logic signed [33:0] lvl_ext;
  logic signed [33:0] band_hi;
  logic signed [33:0] band_lo;
  logic               above;
  logic               below;
  logic               is_corr;

  // Band edges in 34-bit range so the sums never overflow.
  assign lvl_ext = {{2{level[31]}}, level};
  assign band_hi = {{2{cfg.threshold[31]}}, cfg.threshold} + $signed({2'b00, cfg.hyst_mag});
  assign band_lo = {{2{cfg.threshold[31]}}, cfg.threshold} - $signed({2'b00, cfg.hyst_mag});
  assign above   = lvl_ext > band_hi;
  assign below   = lvl_ext < band_lo;
  assign is_corr = (action == hss_pkg::ACT_CORR);

  // With zero hysteresis both edges equal the threshold, so "above" is the
  // plain threshold compare. Levels on an edge count as inside the band.
  always_comb begin
    next_state = old_state;
    unique case (action) inside
      hss_pkg::ACT_INIT: begin
        if (cfg.start_on) begin
          next_state = above ? hss_pkg::ST_REALLY_ON : hss_pkg::ST_HYST_ON;
        end else begin
          next_state = below ? hss_pkg::ST_REALLY_OFF : hss_pkg::ST_HYST_OFF;
        end
      end
      hss_pkg::ACT_SMSIG: begin
        next_state = prior;
      end
      hss_pkg::ACT_CORR, hss_pkg::ACT_PRED: begin
        if (cfg.hyst_zero) begin
          next_state = above ? hss_pkg::ST_REALLY_ON : hss_pkg::ST_REALLY_OFF;
        end else if (above) begin
          next_state = hss_pkg::ST_REALLY_ON;
        end else if (below) begin
          next_state = hss_pkg::ST_REALLY_OFF;
        end else if (!cfg.hyst_neg) begin
          next_state = is_corr ? old_state : prior;
        end else begin
          // Negative hysteresis inside the band flips a hard prior state.
          case (prior)
            hss_pkg::ST_REALLY_ON:
              next_state = is_corr ? hss_pkg::ST_HYST_OFF : hss_pkg::ST_REALLY_OFF;
            hss_pkg::ST_REALLY_OFF:
              next_state = is_corr ? hss_pkg::ST_HYST_ON : hss_pkg::ST_REALLY_ON;
            default:
              next_state = prior;
          endcase
        end
      end
      default: begin
        // No-op phase and unused codes hold the state.
        next_state = old_state;
      end
    endcase
  end

endmodule

>>> hw/rtl/hysteresis_switch_state_top.sv
// Top level of the hysteresis switch block: input register, state and result register.
// Usage:
//   Input channel: in_valid, in_stall, ctrl_level (signed Q16.16) and action (phase).
//   Result channel: out_valid, out_stall, switch_state, is_on, conductance, changed,
//   shrink_step. One result for every input transfer, in order.
//   Configuration: cfg_valid, cfg_ready, cfg_index, cfg_data; cfg_ready is always high.
//   Write registers only while no item is in flight. Writing start_on reloads the
//   present and prior switch states.
// Timing:
//   An item lands in the input register at its transfer and moves on to the result
//   register once that register is empty or its result is taken.
//   Throughput is one item per cycle while out_stall is low; the switch state is fed back
//   around the next-state logic, which sits between the input and result registers.
// Reset (rst, synchronous): both pipeline stages empty, switch states hysteresis off,
//   change flags cleared, registers at their reset values.
// Stall: while out_stall holds the result, the input register still fills; once both
//   are full, in_stall rises in the same cycle and the state stops advancing.
`include "hysteresis_switch_state_top_defines.svh"

module hysteresis_switch_state_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] ctrl_level,
  input  logic [2:0]         action,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         switch_state,
  output logic               is_on,
  output logic [31:0]        conductance,
  output logic               changed,
  output logic               shrink_step
);

  hss_pkg::cfg_t        cfg;
  hss_pkg::state_load_t load;

  logic               s1_valid;
  logic signed [31:0] s1_level;
  logic [2:0]         s1_action;

  hss_pkg::sw_state_t present_state;
  hss_pkg::sw_state_t prior_state;
  logic               change_flag;
  logic               prior_change_flag;

  hss_pkg::sw_state_t prior_eff;
  hss_pkg::sw_state_t state_next;
  logic               change_flag_next;
  logic               prior_change_flag_next;
  logic               new_on;

  logic adv_out;
  logic s1_fire;
  logic in_fire;
  logic cfg_fire;

  hss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .load      (load)
  );

  // Pipeline handshake: the result register frees when empty or taken.
  assign adv_out  = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && adv_out;
  assign in_stall = s1_valid && !adv_out;
  assign in_fire  = in_valid && !in_stall;
  assign cfg_fire = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_fire || (s1_valid && !adv_out);
      out_valid <= s1_fire || (out_valid && out_stall);
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_level  <= ctrl_level;
      s1_action <= action;
    end
  end

  // The predictor rotates present into prior before the rule is applied.
  always_comb begin
    prior_eff              = prior_state;
    prior_change_flag_next = prior_change_flag;
    if (s1_action == hss_pkg::ACT_PRED) begin
      prior_eff              = present_state;
      prior_change_flag_next = change_flag;
    end
  end

  hss_next u_next (
    .level      (s1_level),
    .action     (s1_action),
    .old_state  (present_state),
    .prior      (prior_eff),
    .cfg        (cfg),
    .next_state (state_next)
  );

  assign change_flag_next = (s1_action == hss_pkg::ACT_CORR) && (state_next != present_state);
  assign new_on           = state_next[1];

  // Switch state and change flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      present_state     <= hss_pkg::ST_HYST_OFF;
      prior_state       <= hss_pkg::ST_HYST_OFF;
      change_flag       <= 1'b0;
      prior_change_flag <= 1'b0;
    end else if (load.valid) begin
      present_state <= load.value;
      prior_state   <= load.value;
    end else if (s1_fire) begin
      present_state     <= state_next;
      prior_state       <= (s1_action == hss_pkg::ACT_INIT) ? state_next : prior_eff;
      change_flag       <= change_flag_next;
      prior_change_flag <= prior_change_flag_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      switch_state <= state_next;
      is_on        <= new_on;
      conductance  <= new_on ? cfg.on_cond : cfg.off_cond;
      changed      <= change_flag_next;
      shrink_step  <= prior_change_flag_next;
    end
  end

  // Checks on the state update and result register.
  `HSS_ASSERT_NEXT(a_changed_only_corr, s1_fire && (s1_action != hss_pkg::ACT_CORR), !changed)
  `HSS_ASSERT_NEXT(a_init_aligns_prior, s1_fire && (s1_action == hss_pkg::ACT_INIT) && !load.valid, prior_state == present_state)
  `HSS_ASSERT_NEXT(a_reload_soft_state, load.valid, (present_state == hss_pkg::ST_HYST_ON) || (present_state == hss_pkg::ST_HYST_OFF))
  `HSS_ASSERT_NOW(a_result_tracks_state, out_valid && !s1_valid && !cfg_fire, switch_state == present_state)

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for the hysteresis switch block: a directed table, then random items checked against a predictor.
module tb;

  // Phase code with every bit set; codes above the predictor act as the no-op phase.
  localparam logic [2:0] ACT_CODE_MAX  = 3'd7;
  // Highest register index the port can carry; indexes past the last register are ignored.
  localparam logic [2:0] REG_INDEX_MAX = 3'd7;
  localparam int         ROWS          = 27;
  localparam int         HOLD_CYCLES   = 150;

  typedef struct packed {
    hss_pkg::sw_state_t st;
    logic               on;
    logic [31:0]        cond;
    logic               chg;
    logic               shrink;
  } sw_result_t;

  // One row of the directed table; the expected fields count only when has_exp is set.
  typedef struct packed {
    logic [1:0]  seg;
    logic [31:0] lvl;
    logic [2:0]  act;
    logic        has_exp;
    logic [1:0]  exp_st;
    logic        exp_on;
    logic [31:0] exp_cond;
    logic        exp_chg;
    logic        exp_shrink;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] ctrl_level;
  logic [2:0]         action;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         switch_state;
  logic               is_on;
  logic [31:0]        conductance;
  logic               changed;
  logic               shrink_step;

  hysteresis_switch_state_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .ctrl_level   (ctrl_level),
    .action       (action),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .switch_state (switch_state),
    .is_on        (is_on),
    .conductance  (conductance),
    .changed      (changed),
    .shrink_step  (shrink_step)
  );

  // Shadow copy of the configuration and of the switch state.
  logic signed [31:0] m_threshold;
  logic signed [31:0] m_hyst;
  logic               m_start_on;
  logic [31:0]        m_on_cond;
  logic [31:0]        m_off_cond;
  hss_pkg::sw_state_t p_state;
  hss_pkg::sw_state_t p_prior;
  logic               p_chg;
  logic               p_chg_prior;

  sw_result_t switch_expect_q[$];
  stim_row_t  pending_rows_q[$];
  stim_row_t  stim_rows [ROWS];

  int mismatches;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_req;
  logic signed [31:0] cur_thr;
  logic signed [31:0] cur_hyst;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  // Register write into the shadow configuration.
  function automatic void shadow_reg_write(logic [2:0] idx, logic [31:0] data);
    case (idx)
      hss_pkg::REG_THRESHOLD: m_threshold = data;
      hss_pkg::REG_HYST:      m_hyst = data;
      hss_pkg::REG_START_ON: begin
        m_start_on = data[0];
        p_state = data[0] ? hss_pkg::ST_HYST_ON : hss_pkg::ST_HYST_OFF;
        p_prior = p_state;
      end
      hss_pkg::REG_ON_COND:   m_on_cond = data;
      hss_pkg::REG_OFF_COND:  m_off_cond = data;
      default: ;
    endcase
  endfunction

  // Advance the switch state by one item and return the result it produces.
  function automatic sw_result_t predict_switch(logic signed [31:0] lvl, logic [2:0] act);
    logic signed [33:0] lv, th, hv, mag, hi, lo;
    hss_pkg::sw_state_t old_st, nxt;
    sw_result_t         r;
    lv = 34'(lvl);
    th = 34'(m_threshold);
    hv = 34'(m_hyst);
    mag = (hv < 0) ? -hv : hv;
    hi = th + mag;
    lo = th - mag;
    if (act == hss_pkg::ACT_PRED) begin
      p_chg_prior = p_chg;
      p_prior = p_state;
    end
    old_st = p_state;
    if (act == hss_pkg::ACT_INIT) begin
      if (m_start_on) nxt = (lv > hi) ? hss_pkg::ST_REALLY_ON : hss_pkg::ST_HYST_ON;
      else nxt = (lv < lo) ? hss_pkg::ST_REALLY_OFF : hss_pkg::ST_HYST_OFF;
    end else if (act == hss_pkg::ACT_SMSIG) nxt = p_prior;
    else if (act != hss_pkg::ACT_CORR && act != hss_pkg::ACT_PRED) nxt = old_st;
    else if (hv == 0) nxt = (lv > th) ? hss_pkg::ST_REALLY_ON : hss_pkg::ST_REALLY_OFF;
    else if (lv > hi) nxt = hss_pkg::ST_REALLY_ON;
    else if (lv < lo) nxt = hss_pkg::ST_REALLY_OFF;
    else if (hv > 0) nxt = (act == hss_pkg::ACT_CORR) ? old_st : p_prior;
    // Negative hysteresis inside the band: the prior state decides.
    else if (p_prior == hss_pkg::ST_HYST_OFF || p_prior == hss_pkg::ST_HYST_ON) nxt = p_prior;
    else if (p_prior == hss_pkg::ST_REALLY_ON)
      nxt = (act == hss_pkg::ACT_CORR) ? hss_pkg::ST_HYST_OFF : hss_pkg::ST_REALLY_OFF;
    else nxt = (act == hss_pkg::ACT_CORR) ? hss_pkg::ST_HYST_ON : hss_pkg::ST_REALLY_ON;
    p_chg = (act == hss_pkg::ACT_CORR) && (nxt != old_st);
    p_state = nxt;
    if (act == hss_pkg::ACT_INIT) p_prior = nxt;
    r.st = nxt;
    r.on = (nxt == hss_pkg::ST_HYST_ON) || (nxt == hss_pkg::ST_REALLY_ON);
    r.cond = r.on ? m_on_cond : m_off_cond;
    r.chg = p_chg;
    r.shrink = p_chg_prior;
    return r;
  endfunction

  // Track every transfer on the three channels and compare results in order.
  always @(posedge clk) begin
    sw_result_t want;
    sw_result_t got;
    stim_row_t  row;
    if (rst) begin
      m_threshold = 32'sd0;
      m_hyst = 32'sd0;
      m_start_on = 1'b0;
      m_on_cond = hss_pkg::ON_COND_RESET;
      m_off_cond = hss_pkg::OFF_COND_RESET;
      p_state = hss_pkg::ST_HYST_OFF;
      p_prior = hss_pkg::ST_HYST_OFF;
      p_chg = 1'b0;
      p_chg_prior = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) shadow_reg_write(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        want = predict_switch(ctrl_level, action);
        if (pending_rows_q.size() > 0) begin
          row = pending_rows_q.pop_front();
          if (row.has_exp) begin
            want = '{hss_pkg::sw_state_t'(row.exp_st), row.exp_on, row.exp_cond, row.exp_chg,
                     row.exp_shrink};
          end
        end
        switch_expect_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = '{hss_pkg::sw_state_t'(switch_state), is_on, conductance, changed, shrink_step};
        if (switch_expect_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = switch_expect_q.pop_front();
          check_field("switch_state", 32'(got.st), 32'(want.st));
          check_field("is_on", 32'(got.on), 32'(want.on));
          check_field("conductance", got.cond, want.cond);
          check_field("changed", 32'(got.chg), 32'(want.chg));
          check_field("shrink_step", 32'(got.shrink), 32'(want.shrink));
        end
      end
    end
  end

  // Result side: random stall, plus one long hold-off each time one is requested.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Lower the input valid and wait until every expected result has come out.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (switch_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  task automatic apply_settings(input logic [31:0] thr, input logic [31:0] hyst,
                                input logic son, input logic [31:0] onc,
                                input logic [31:0] offc, input logic write_son);
    wait_idle();
    write_reg(hss_pkg::REG_THRESHOLD, thr);
    write_reg(hss_pkg::REG_HYST, hyst);
    write_reg(hss_pkg::REG_ON_COND, onc);
    write_reg(hss_pkg::REG_OFF_COND, offc);
    if (write_son) write_reg(hss_pkg::REG_START_ON, {31'd0, son});
    if ($urandom_range(3) == 0) begin
      write_reg(3'($urandom_range(hss_pkg::REG_OFF_COND + 1, REG_INDEX_MAX)), $urandom);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_thr = thr;
    cur_hyst = hyst;
  endtask

  // Offer one item after a random gap and hold it until the transfer.
  task automatic send_item(input logic [31:0] lvl, input logic [2:0] act);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    ctrl_level <= lvl;
    action <= act;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // Level near the band edges most of the time, anywhere in range otherwise.
  function automatic logic [31:0] pick_level(logic signed [31:0] thr, logic signed [31:0] hy);
    longint t, m, v;
    t = longint'(thr);
    m = (hy < 0) ? -longint'(hy) : longint'(hy);
    case ($urandom_range(9))
      0, 1: v = longint'($signed($urandom));
      2: v = t + m;
      3: v = t - m;
      4: v = t + m + 1;
      5: v = t - m - 1;
      6: v = t;
      default: v = t + (longint'($urandom) % (2 * m + 9)) - (m + 4);
    endcase
    if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) v = -64'sh8000_0000;
    return v[31:0];
  endfunction

  // Mostly predictor and corrector steps, as a transient analysis issues them.
  function automatic logic [2:0] pick_action();
    int r;
    r = $urandom_range(99);
    if (r < 35) return hss_pkg::ACT_CORR;
    if (r < 65) return hss_pkg::ACT_PRED;
    if (r < 75) return hss_pkg::ACT_INIT;
    if (r < 83) return hss_pkg::ACT_SMSIG;
    if (r < 90) return hss_pkg::ACT_NONE;
    return 3'($urandom_range(hss_pkg::ACT_PRED + 1, ACT_CODE_MAX));
  endfunction

  task automatic random_settings();
    logic [31:0] thr, hyst, onc, offc;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: thr = $urandom_range(0, 32'h8_0000) - 32'h4_0000;
      6: thr = 32'h7FFF_FFFF;
      7: thr = 32'h8000_0000;
      default: thr = $urandom;
    endcase
    case ($urandom_range(9))
      0, 1, 2: hyst = 32'h0;
      3, 4, 5: hyst = $urandom_range(1, 32'h4_0000);
      6, 7, 8: hyst = -$urandom_range(1, 32'h4_0000);
      default: begin
        case ($urandom_range(2))
          0: hyst = 32'h8000_0000;
          1: hyst = 32'h7FFF_FFFF;
          default: hyst = $urandom;
        endcase
      end
    endcase
    onc = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF : $urandom;
    offc = ($urandom_range(7) == 0) ? 32'h0 : $urandom;
    apply_settings(thr, hyst, 1'($urandom_range(1)), onc, offc, 1'($urandom_range(1)));
  endtask

  // Main sequence.
  initial begin
    int   items;
    int   next_cfg;
    logic [1:0] cur_seg;
    stim_row_t  row;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = hss_pkg::REG_THRESHOLD;
    cfg_data = 32'h0;
    in_valid = 1'b0;
    ctrl_level = 32'sd0;
    action = hss_pkg::ACT_NONE;
    mismatches = 0;
    hold_req = 0;
    tx_idle_pct = 30;
    rx_idle_pct = 53;
    cur_thr = 32'sd0;
    cur_hyst = 32'sd0;

    // Segment 0 runs on reset values; 1 has positive hysteresis with start_on,
    // 2 negative hysteresis, 3 the most negative hysteresis at the top threshold.
    stim_rows = '{
      '{2'd0, 32'h0000_0000, hss_pkg::ACT_NONE, 1'b1, hss_pkg::ST_HYST_OFF, 1'b0, 32'h0,
        1'b0, 1'b0},
      '{2'd0, 32'hFFFF_FFFF, hss_pkg::ACT_INIT, 1'b1, hss_pkg::ST_REALLY_OFF, 1'b0, 32'h0,
        1'b0, 1'b0},
      '{2'd0, 32'h7FFF_FFFF, hss_pkg::ACT_CORR, 1'b1, hss_pkg::ST_REALLY_ON, 1'b1,
        hss_pkg::ON_COND_RESET, 1'b1, 1'b0},
      '{2'd0, 32'h8000_0000, hss_pkg::ACT_CORR, 1'b1, hss_pkg::ST_REALLY_OFF, 1'b0, 32'h0,
        1'b1, 1'b0},
      '{2'd0, 32'h0000_0000, hss_pkg::ACT_PRED, 1'b1, hss_pkg::ST_REALLY_OFF, 1'b0, 32'h0,
        1'b0, 1'b1},
      '{2'd0, 32'h0000_0001, hss_pkg::ACT_SMSIG, 1'b1, hss_pkg::ST_REALLY_OFF, 1'b0, 32'h0,
        1'b0, 1'b1},
      '{2'd0, 32'h0000_0001, ACT_CODE_MAX, 1'b1, hss_pkg::ST_REALLY_OFF, 1'b0, 32'h0,
        1'b0, 1'b1},
      '{2'd1, 32'h0003_0000, hss_pkg::ACT_INIT,  1'b0, 2'd0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd1, 32'h0003_0001, hss_pkg::ACT_INIT,  1'b0, 2'd0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd1, 32'h0002_0000, hss_pkg::ACT_CORR,  1'b0, 2'd0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd1, 32'h0001_0000, hss_pkg::ACT_CORR,  1'b0, 2'd0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd1, 32'h0000_FFFF, hss_pkg::ACT_CORR,  1'b0, 2'd0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd1, 32'h0002_0000, hss_pkg::ACT_PRED,  1'b0, 2'd0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd1, 32'h0003_0001, hss_pkg::ACT_CORR,  1'b0, 2'd0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd1, 32'h0002_0000, hss_pkg::ACT_PRED,  1'b0, 2'd0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd2, 32'h0000_0000, hss_pkg::ACT_PRED,  1'b0, 2'd0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd2, 32'hFFFF_0000, hss_pkg::ACT_INIT,  1'b0, 2'd0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd2, 32'h0001_0001, hss_pkg::ACT_PRED,  1'b0, 2'd0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd2, 32'h0001_0001, hss_pkg::ACT_PRED,  1'b0, 2'd0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd2, 32'h0000_0000, hss_pkg::ACT_PRED,  1'b0, 2'd0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd2, 32'h0000_0000, hss_pkg::ACT_CORR,  1'b0, 2'd0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd2, 32'hFFFE_FFFF, hss_pkg::ACT_CORR,  1'b0, 2'd0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd2, 32'h0000_0000, hss_pkg::ACT_PRED,  1'b0, 2'd0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd2, 32'h0000_0000, hss_pkg::ACT_CORR,  1'b0, 2'd0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd3, 32'h7FFF_FFFF, hss_pkg::ACT_INIT,  1'b0, 2'd0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd3, 32'h8000_0000, hss_pkg::ACT_CORR,  1'b0, 2'd0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{2'd3, 32'hFFFF_FFFF, hss_pkg::ACT_PRED,  1'b0, 2'd0, 1'b0, 32'h0, 1'b0, 1'b0}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table, switching the configuration where the segment changes.
    cur_seg = 2'd0;
    for (int i = 0; i < ROWS; i++) begin
      row = stim_rows[i];
      if (row.seg != cur_seg) begin
        cur_seg = row.seg;
        case (cur_seg)
          2'd1: apply_settings(32'h0002_0000, 32'h0001_0000, 1'b1, 32'hFFFF_FFFF,
                               32'h1234_5678, 1'b1);
          2'd2: apply_settings(32'h0000_0000, 32'hFFFF_0000, 1'b0, 32'h0000_0001,
                               32'hFFFF_FFFF, 1'b1);
          default: apply_settings(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0,
                                  32'h0001_0000, 1'b1);
        endcase
      end
      pending_rows_q.push_back(row);
      send_item(row.lvl, row.act);
    end

    // Random part in three idle patterns, with a fresh configuration every so often.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 30; rx_idle_pct = 53; end
        1: begin tx_idle_pct = 53; rx_idle_pct = 30; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      items = 0;
      next_cfg = 0;
      while (items < 567) begin
        if (items == next_cfg) begin
          random_settings();
          next_cfg = items + $urandom_range(40, 120);
        end
        // Hold the result side off for a long stretch so the block fills up.
        if ((ph == 0 && items == 200) || (ph == 2 && items == 100)) hold_req++;
        send_item(pick_level(cur_thr, cur_hyst), pick_action());
        items++;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (switch_expect_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> hysteresis_switch_state_top.f
+incdir+hw/rtl
hw/rtl/hss_pkg.sv
hw/rtl/hss_cfg.sv
hw/rtl/hss_next.sv
hw/rtl/hysteresis_switch_state_top.sv
tb/tb.sv
